>>> sv/matrix3_inverse_top_assert.svh
// Assertion helpers used by the checker file.
`ifndef MATRIX3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3_INVERSE_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define MI3_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mi3_pkg.sv
`default_nettype none
package mi3_pkg;
  // default element format, Q16.16 in 32 bits
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  // register stages ahead of the divider lanes
  localparam int FRONT_STAGES   = 5;
endpackage
`default_nettype wire

>>> sv/mi3_front.sv
`default_nettype none
// Cofactors and determinant: five register stages.
module mi3_front #(
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [ELEM_WIDTH-1:0]   elem [9],
  output logic signed [2*ELEM_WIDTH:0]        cof [9],
  output logic signed [3*ELEM_WIDTH+2:0]      det
);
  localparam int W  = ELEM_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int LO = W + 1;
  localparam int DW = 3 * W + 3;
  localparam int TW = 3 * W + 1;

  logic signed [PW-1:0]     pa_r [9];
  logic signed [PW-1:0]     pb_r [9];
  logic signed [W-1:0]      m1_r [3];
  logic signed [W-1:0]      m2_r [3];
  logic signed [CW-1:0]     cof2_r [9];
  logic signed [CW-1:0]     cof3_r [9];
  logic signed [CW-1:0]     cof4_r [9];
  logic signed [CW-1:0]     cof5_r [9];
  logic signed [PW+1:0]     plo_r [3];
  logic signed [PW-1:0]     phi_r [3];
  logic signed [TW-1:0]     term_r [3];
  logic signed [DW-1:0]     det_r;

  genvar k;
  generate
    for (k = 0; k < 9; k++) begin : g_cof
      localparam int C  = k / 3;
      localparam int R  = k % 3;
      localparam int C0 = (C == 0) ? 1 : 0;
      localparam int C1 = (C == 2) ? 1 : 2;
      localparam int R0 = (R == 0) ? 1 : 0;
      localparam int R1 = (R == 2) ? 1 : 2;
      logic signed [CW-1:0] diff;

      // minor as a difference of two products, sign from position
      assign diff = CW'(pa_r[k]) - CW'(pb_r[k]);

      always_ff @(posedge clk) begin
        if (en) begin
          pa_r[k]   <= PW'(elem[C0*3+R0] * elem[C1*3+R1]);
          pb_r[k]   <= PW'(elem[C0*3+R1] * elem[C1*3+R0]);
          cof2_r[k] <= ((C + R) % 2 == 1) ? -diff : diff;
          cof3_r[k] <= cof2_r[k];
          cof4_r[k] <= cof3_r[k];
          cof5_r[k] <= cof4_r[k];
        end
      end
    end

    for (k = 0; k < 3; k++) begin : g_det
      logic [LO-1:0]         lo;
      logic signed [W-1:0]   hi;
      logic signed [LO:0]    lo_s;

      // first-row element times cofactor, split in two partial products
      assign lo   = cof2_r[3*k][LO-1:0];
      assign hi   = cof2_r[3*k][CW-1:LO];
      assign lo_s = {1'b0, lo};

      always_ff @(posedge clk) begin
        if (en) begin
          m1_r[k]   <= elem[3*k];
          m2_r[k]   <= m1_r[k];
          plo_r[k]  <= (PW+2)'(m2_r[k] * lo_s);
          phi_r[k]  <= PW'(m2_r[k] * hi);
          term_r[k] <= (TW'(phi_r[k]) <<< LO) + TW'(plo_r[k]);
        end
      end
    end
  endgenerate

  // determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= DW'(term_r[0]) + DW'(term_r[1]) + DW'(term_r[2]);
    end
  end

  assign cof = cof5_r;
  assign det = det_r;
endmodule
`default_nettype wire

>>> sv/mi3_div_lane.sv
`default_nettype none
// One inverse element: cofactor scaled by 2^(2F) over the determinant,
// restoring division with one quotient bit per stage, saturated.
module mi3_div_lane #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [2*ELEM_WIDTH:0]  cof,
  input  wire logic signed [3*ELEM_WIDTH+2:0] det,
  output logic signed [ELEM_WIDTH-1:0]       inv
);
  localparam int W  = ELEM_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int DW = 3 * W + 3;
  localparam int SW = DW + W - 1;

  logic signed [NW-1:0] num;
  logic [NW-1:0]        nmag;
  logic [DW-1:0]        dmag;

  logic [NW-1:0]  rem_r  [W];
  logic [DW-1:0]  dmag_r [W];
  logic [W-2:0]   q_r    [W];
  logic           neg_r  [W];
  logic           sat_r  [W];
  logic [W-1:0]   qv;

  // magnitudes and early overflow test: quotient >= 2^(W-1) saturates
  assign num  = {cof, {(2*FRAC_BITS){1'b0}}};
  assign nmag = num[NW-1] ? (~num + 1'b1) : num;
  assign dmag = det[DW-1] ? (~det + 1'b1) : det;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= nmag;
      dmag_r[0] <= dmag;
      q_r[0]    <= '0;
      neg_r[0]  <= num[NW-1] ^ det[DW-1];
      sat_r[0]  <= SW'(nmag) >= (SW'(dmag) << (W - 1));
    end
  end

  genvar s;
  generate
    for (s = 1; s < W; s++) begin : g_stage
      localparam int B = W - 1 - s;
      logic [SW-1:0] dsh;
      logic [SW-1:0] remx;
      logic          ge;

      assign dsh  = SW'(dmag_r[s-1]) << B;
      assign remx = SW'(rem_r[s-1]);
      assign ge   = remx >= dsh;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s]  <= ge ? NW'(remx - dsh) : rem_r[s-1];
          dmag_r[s] <= dmag_r[s-1];
          q_r[s]    <= q_r[s-1] | (ge ? ((W-1)'(1) << B) : '0);
          neg_r[s]  <= neg_r[s-1];
          sat_r[s]  <= sat_r[s-1];
        end
      end
    end
  endgenerate

  // sign and saturation
  assign qv = {1'b0, q_r[W-1]};
  always_comb begin
    if (sat_r[W-1]) begin
      inv = neg_r[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      inv = neg_r[W-1] ? -qv : qv;
    end
  end
endmodule
`default_nettype wire

>>> sv/matrix3_inverse_top.sv
`default_nettype none
// 3x3 matrix inverse by adjugate over determinant, signed fixed point.
// Input channel: in_valid / in_stall with nine elements in column-major order.
// Output channel: out_valid / out_stall with nine inverse elements, same order,
// and out_singular, set with all-zero elements when the determinant is zero.
// Elements above range saturate to the largest or smallest code.
// Throughput: one matrix per cycle while the output is not stalled. The
// pipeline has five stages for products, cofactors and determinant,
// ELEM_WIDTH stages of restoring division, a setup stage with the overflow
// test and then one quotient bit per stage, and the output register.
// The whole pipeline advances together; it holds only when a word sits in
// the output register and out_stall is high, and then in_stall is raised and
// every stage keeps its data, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data in flight is
// dropped. No state carries from one matrix to the next.
module matrix3_inverse_top #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem0,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem1,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem2,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem3,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem4,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem5,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem6,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem7,
  input  wire logic signed [ELEM_WIDTH-1:0] in_elem8,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [ELEM_WIDTH-1:0]      out_inv0,
  output logic signed [ELEM_WIDTH-1:0]      out_inv1,
  output logic signed [ELEM_WIDTH-1:0]      out_inv2,
  output logic signed [ELEM_WIDTH-1:0]      out_inv3,
  output logic signed [ELEM_WIDTH-1:0]      out_inv4,
  output logic signed [ELEM_WIDTH-1:0]      out_inv5,
  output logic signed [ELEM_WIDTH-1:0]      out_inv6,
  output logic signed [ELEM_WIDTH-1:0]      out_inv7,
  output logic signed [ELEM_WIDTH-1:0]      out_inv8,
  output logic                              out_singular
);
  import mi3_pkg::*;

  localparam int W    = ELEM_WIDTH;
  localparam int CW   = 2 * W + 1;
  localparam int DW   = 3 * W + 3;
  localparam int PIPE = FRONT_STAGES + W;

  logic                 en;
  logic signed [W-1:0]  elem [9];
  logic signed [CW-1:0] cof [9];
  logic signed [DW-1:0] det;
  logic signed [W-1:0]  lane [9];
  logic signed [W-1:0]  inv_r [9];
  logic                 vld_r [PIPE];
  logic                 sing_r [W];
  logic                 out_valid_r;
  logic                 out_sing_r;

  // advance unless a word waits in the output register
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign elem[0] = in_elem0;
  assign elem[1] = in_elem1;
  assign elem[2] = in_elem2;
  assign elem[3] = in_elem3;
  assign elem[4] = in_elem4;
  assign elem[5] = in_elem5;
  assign elem[6] = in_elem6;
  assign elem[7] = in_elem7;
  assign elem[8] = in_elem8;

  mi3_front #(.ELEM_WIDTH(ELEM_WIDTH)) u_front (
    .clk  (clk),
    .en   (en),
    .elem (elem),
    .cof  (cof),
    .det  (det)
  );

  // inverse at column c, row r takes the cofactor at column r, row c
  genvar k;
  generate
    for (k = 0; k < 9; k++) begin : g_lane
      mi3_div_lane #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
        .clk (clk),
        .en  (en),
        .cof (cof[(k % 3) * 3 + (k / 3)]),
        .det (det),
        .inv (lane[k])
      );
    end
  endgenerate

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < PIPE; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  // singular flag beside the divider stages, then the output word
  always_ff @(posedge clk) begin
    if (en) begin
      sing_r[0] <= (det == '0);
      for (int i = 1; i < W; i++) begin
        sing_r[i] <= sing_r[i-1];
      end
      out_sing_r <= sing_r[W-1];
      for (int i = 0; i < 9; i++) begin
        inv_r[i] <= sing_r[W-1] ? '0 : lane[i];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_singular = out_sing_r;
  assign out_inv0     = inv_r[0];
  assign out_inv1     = inv_r[1];
  assign out_inv2     = inv_r[2];
  assign out_inv3     = inv_r[3];
  assign out_inv4     = inv_r[4];
  assign out_inv5     = inv_r[5];
  assign out_inv6     = inv_r[6];
  assign out_inv7     = inv_r[7];
  assign out_inv8     = inv_r[8];
endmodule
`default_nettype wire

>>> sv/mi3_checker.sv
`default_nettype none
`include "matrix3_inverse_top_assert.svh"
// Port-level checks on the inverse block.
module mi3_checker #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [ELEM_WIDTH-1:0] out_inv0,
  input wire logic [ELEM_WIDTH-1:0] out_inv4,
  input wire logic [ELEM_WIDTH-1:0] out_inv8,
  input wire logic                  out_singular
);
  // a stalled word stays valid and keeps element 0
  `MI3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_inv0), "stalled word dropped")
  // a singular word carries zeros in elements 0, 4 and 8
  `MI3_ASSERT_IMPL(a_sing_zero, out_valid && out_singular, out_inv0 == '0 && out_inv4 == '0 && out_inv8 == '0, "singular word not zero")
  // the input side holds only behind a waiting output word
  `MI3_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "input held without cause")
  // an output word that waits keeps the input side held
  `MI3_ASSERT_IMPL(a_stall_back, out_valid && out_stall, in_stall, "input taken while output full")
endmodule

bind matrix3_inverse_top mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_inv0     (out_inv0),
  .out_inv4     (out_inv4),
  .out_inv8     (out_inv8),
  .out_singular (out_singular)
);
`default_nettype wire
